// File: rtl/dqs_pkg.sv
// Shared types and constants for the double-ended queue with search.
// No dependencies; imported by the interfaces, the top level, the checkers and the testbench.
`default_nettype none

package dqs_pkg;

    localparam int VALUE_W = 32;
    localparam int FILL_W  = 5;

    typedef enum logic [1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_PUSH_BACK  = 2'd1,
        FN_SEARCH     = 2'd2,
        FN_READ_LAST  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                      found;
        logic signed [VALUE_W-1:0] last_value;
        t_status                   status;
        logic [FILL_W-1:0]         fill_level;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/dqs_if.sv
// Valid/ready channel interfaces for command beats and result beats.
// Depends on dqs_pkg for field widths.
`default_nettype none

interface dqs_in_if;
    import dqs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                func;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface dqs_out_if;
    import dqs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic signed [VALUE_W-1:0] last_value;
    logic [1:0]                status;
    logic [FILL_W-1:0]         fill_level;

    modport source (output valid, output found, output last_value, output status,
                    output fill_level, input ready);
    modport sink   (input valid, input found, input last_value, input status,
                    input fill_level, output ready);
endinterface

`default_nettype wire

// File: rtl/deque_with_search_top.sv
// Channel    | Dir | Beat contents
// -----------+-----+------------------------------------------------
// i_in       | in  | func (2 b), value (32 b signed)
// o_out      | out | found, last_value (32 b signed), status, fill_level
//
// One command at a time; the store sits in a single-port RAM (dqs_ram).
// Push writes the RAM when taken; read last reads the last slot. Search compares
// n entries from the front (n at most the fill level), one RAM read a cycle.
// A new command is taken the cycle after the result moves into the output
// register, even while that register still waits on o_out.ready.
// Synchronous active-low reset empties the queue; RAM contents are not cleared.
// Depends on dqs_pkg, dqs_if and dqs_ram.
`default_nettype none

module deque_with_search_top import dqs_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dqs_in_if.sink      i_in,
    dqs_out_if.source   o_out
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_LAST,
        S_DONE
    } t_state;

    function automatic logic [IW-1:0] f_wrap(input logic [IW:0] sum);
        return (sum >= DEPTH_X) ? IW'(sum - DEPTH_X) : IW'(sum);
    endfunction

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    t_state                    r_state, n_state;
    logic [IW-1:0]             r_front, n_front;
    logic [CW-1:0]             r_count, n_count;
    logic [IW-1:0]             r_ptr, n_ptr;
    logic [CW-1:0]             r_left, n_left;
    logic signed [VALUE_W-1:0] r_value, n_value;
    t_result                   r_res, n_res;
    t_result                   r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic                      ram_we;
    logic [IW-1:0]             ram_addr;
    logic [VALUE_W-1:0]        ram_rdata;

    logic                      accept;
    logic                      out_free;
    logic                      is_full;
    logic                      is_empty;
    logic [IW-1:0]             front_dec;
    logic [IW-1:0]             back_slot;
    logic [IW-1:0]             last_slot;

    assign accept    = i_in.valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || o_out.ready;
    assign is_full   = (r_count == FULL_CNT);
    assign is_empty  = (r_count == '0);
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    // count is below DEPTH whenever these slots are used, so it fits the index
    assign back_slot = f_wrap({1'b0, r_front} + {1'b0, IW'(r_count)});
    assign last_slot = f_wrap({1'b0, r_front} + {1'b0, IW'(r_count - 1'b1)});

    dqs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in.value),
        .o_rdata (ram_rdata)
    );

    // Commands run one at a time, so a write and a later read of the same
    // slot never overlap and no forwarding is needed.
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_value     = r_value;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        ram_we      = 1'b0;
        ram_addr    = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_value = i_in.value;
                    n_res   = '{found: 1'b0, last_value: '0, status: ST_OK,
                                fill_level: FILL_W'(r_count)};
                    n_state = S_DONE;
                    unique case (t_func'(i_in.func))
                        FN_PUSH_FRONT: begin
                            if (is_full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                ram_we           = 1'b1;
                                ram_addr         = front_dec;
                                n_front          = front_dec;
                                n_count          = r_count + 1'b1;
                                n_res.fill_level = FILL_W'(r_count + 1'b1);
                            end
                        end
                        FN_PUSH_BACK: begin
                            if (is_full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                ram_we           = 1'b1;
                                ram_addr         = back_slot;
                                n_count          = r_count + 1'b1;
                                n_res.fill_level = FILL_W'(r_count + 1'b1);
                            end
                        end
                        FN_SEARCH: begin
                            if (is_empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                ram_addr = r_front;
                                n_ptr    = f_next(r_front);
                                n_left   = r_count;
                                n_state  = S_SEARCH;
                            end
                        end
                        FN_READ_LAST: begin
                            if (is_empty) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                ram_addr = last_slot;
                                n_state  = S_LAST;
                            end
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // compare the word read last cycle, issue the next read
                if (ram_rdata == r_value) begin
                    n_res.found = 1'b1;
                    n_state     = S_DONE;
                end else if (r_left == CW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    ram_addr = r_ptr;
                    n_ptr    = f_next(r_ptr);
                    n_left   = r_left - 1'b1;
                end
            end
            S_LAST: begin
                n_res.last_value = ram_rdata;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_ptr   <= n_ptr;
        r_left  <= n_left;
        r_value <= n_value;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out.found;
    assign o_out.last_value  = r_out.last_value;
    assign o_out.status      = r_out.status;
    assign o_out.fill_level  = r_out.fill_level;

endmodule

`default_nettype wire

// File: rtl/dqs_ram.sv
// Generic single-port RAM, read-first, registered read data.
// No dependencies.
`default_nettype none

module dqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// File: rtl/dqs_checker.sv
// Port-level checks on the result channel of deque_with_search_top.
// Depends on dqs_pkg; bound to the top level at the end of this file.
`default_nettype none

module dqs_checker import dqs_pkg::*; #(
    parameter int DEPTH = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_found,
    input logic signed [VALUE_W-1:0] i_last_value,
    input logic [1:0]                i_status,
    input logic [FILL_W-1:0]         i_fill_level
);

    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

    // hold a stalled result beat
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_found)
            && $stable(i_last_value) && $stable(i_status) && $stable(i_fill_level))
        else $error("result beat changed while stalled");

    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> i_status == ST_OK && i_last_value == '0)
        else $error("found set with non-ok status or last value");

    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_fill_level == FULL_FILL && !i_found)
        else $error("dropped push without a full store");

    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |-> i_fill_level == '0 && !i_found
            && i_last_value == '0)
        else $error("empty status with stored elements");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status == ST_OK || i_status == ST_FULL || i_status == ST_EMPTY)
        else $error("undefined status code");

endmodule

bind deque_with_search_top dqs_checker #(.DEPTH(DEPTH)) u_dqs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_found      (o_out.found),
    .i_last_value (o_out.last_value),
    .i_status     (o_out.status),
    .i_fill_level (o_out.fill_level)
);

`default_nettype wire

// File: tb/sv/deque_result_checker.sv
// Result checker for deque_with_search_top: predicts each result beat from the command beats.
// Watches dqs_in_if and dqs_out_if and compares beats field by field.
// Depends on dqs_pkg and dqs_if.

module deque_result_checker import dqs_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dqs_in_if    i_cmd,
    dqs_out_if   i_res,
    output int   o_fail_count,
    output int   o_checked_count
);

    logic signed [VALUE_W-1:0] store_slots [DEPTH];
    int                        head_slot;
    int                        held_count;
    t_result                   awaited_results [$];

    // Apply one command to the shadow deque and return the result it yields.
    function automatic t_result deque_apply(t_func fn, logic signed [VALUE_W-1:0] v);
        t_result r;
        r        = '0;
        r.status = ST_OK;
        case (fn)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (held_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (fn == FN_PUSH_FRONT) begin
                    head_slot              = (head_slot + DEPTH - 1) % DEPTH;
                    store_slots[head_slot] = v;
                    held_count++;
                end else begin
                    store_slots[(head_slot + held_count) % DEPTH] = v;
                    held_count++;
                end
            end
            FN_SEARCH: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int k = 0; k < held_count; k++) begin
                        if (store_slots[(head_slot + k) % DEPTH] == v)
                            r.found = 1'b1;
                    end
                end
            end
            default: begin
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else
                    r.last_value = store_slots[(head_slot + held_count - 1) % DEPTH];
            end
        endcase
        r.fill_level = FILL_W'(held_count);
        return r;
    endfunction

    task automatic compare_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            head_slot       = 0;
            held_count      = 0;
            o_fail_count    = 0;
            o_checked_count = 0;
            awaited_results.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready)
                awaited_results.push_back(deque_apply(t_func'(i_cmd.func), i_cmd.value));
            if (i_res.valid && i_res.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("found", want.found, i_res.found);
                    compare_field("last_value", want.last_value, i_res.last_value);
                    compare_field("status", want.status, i_res.status);
                    compare_field("fill_level", want.fill_level, i_res.fill_level);
                    o_checked_count++;
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_deque_with_search_top.sv
// Testbench top for deque_with_search_top: clock, reset, command and result traffic, verdict.
// Depends on dqs_pkg, dqs_if, deque_with_search_top and deque_result_checker.

module tb_deque_with_search_top;
    import dqs_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_BEATS = 1440;
    localparam int QUIET_TAIL   = 150;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dqs_in_if  cmd_ch ();
    dqs_out_if res_ch ();

    int  fail_count;
    int  checked_count;
    int  sent_count = 0;
    int  gap_pct    = 30;
    bit  quiet      = 1'b0;

    logic signed [VALUE_W-1:0] pushed_values [$];

    deque_with_search_top #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    deque_result_checker #(.DEPTH(DEPTH)) result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_ch),
        .i_res           (res_ch),
        .o_fail_count    (fail_count),
        .o_checked_count (checked_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("tb_deque_with_search_top failed");
        $finish;
    end

    // Hold the beat until it is taken, then maybe drop valid for a burst.
    task automatic send_cmd(t_func fn, logic signed [VALUE_W-1:0] v);
        cmd_ch.valid <= 1'b1;
        cmd_ch.func  <= fn;
        cmd_ch.value <= v;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        sent_count++;
        if (fn == FN_PUSH_FRONT || fn == FN_PUSH_BACK)
            pushed_values.push_back(v);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Mix extremes, small values that repeat, values already pushed and raw noise.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return -32'sd1;
                default: return 32'sd0;
            endcase
        end else if (sel < 5) begin
            return int'($urandom_range(0, 8)) - 4;
        end else if (sel < 8 && pushed_values.size() != 0) begin
            return pushed_values[$urandom_range(0, pushed_values.size() - 1)];
        end
        return $urandom;
    endfunction

    initial begin
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int sel;
        t_func fn;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func  <= FN_PUSH_FRONT;
        cmd_ch.value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty store, extremes at both ends, hits and misses.
        send_cmd(FN_READ_LAST,  32'sd7);
        send_cmd(FN_SEARCH,     32'sh8000_0000);
        send_cmd(FN_PUSH_BACK,  32'sh8000_0000);
        send_cmd(FN_SEARCH,     32'sh8000_0000);
        send_cmd(FN_READ_LAST,  -32'sd1);
        send_cmd(FN_PUSH_FRONT, 32'sh7fff_ffff);
        send_cmd(FN_SEARCH,     32'sh7fff_ffff);
        send_cmd(FN_SEARCH,     32'sd0);
        send_cmd(FN_READ_LAST,  32'sd0);
        send_cmd(FN_PUSH_BACK,  32'sd0);
        send_cmd(FN_PUSH_FRONT, -32'sd1);
        send_cmd(FN_READ_LAST,  32'sh7fff_ffff);
        send_cmd(FN_SEARCH,     -32'sd1);
        send_cmd(FN_SEARCH,     32'sh5555_5555);
        send_cmd(FN_PUSH_BACK,  32'shaaaa_aaaa);
        send_cmd(FN_SEARCH,     32'shaaaa_aaaa);
        send_cmd(FN_READ_LAST,  32'sh5555_5555);

        // Pushes are rare so searches see every fill level before the store fills up.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 25;
                    default: gap_pct = 60;
                endcase
            end
            if (n == RANDOM_BEATS - QUIET_TAIL)
                quiet = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 8)
                fn = FN_PUSH_FRONT;
            else if (sel < 16)
                fn = FN_PUSH_BACK;
            else if (sel < 70)
                fn = FN_SEARCH;
            else
                fn = FN_READ_LAST;
            send_cmd(fn, pick_value());
        end
        cmd_ch.valid <= 1'b0;

        while (checked_count != sent_count) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_deque_with_search_top passed");
        else
            $display("tb_deque_with_search_top failed");
        $finish;
    end

endmodule
